>>> rtl/pmul_pkg.sv
// Package for the polynomial multiplier: beat payload types, item mode codes,
// and the controller-to-datapath command bundle. No dependencies.
package pmul_pkg;

	localparam int MAX_TERMS_DEF = 32;

	// Item modes
	localparam logic [1:0] MODE_LOAD_A  = 2'd0;
	localparam logic [1:0] MODE_LOAD_B  = 2'd1;
	localparam logic [1:0] MODE_COMPUTE = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [4:0]         degree;
		logic signed [31:0] coefficient;
	} item_t;

	typedef struct packed {
		logic [5:0]         result_degree;
		logic signed [31:0] result_coefficient;
		logic               last;
	} result_t;

	// Tag riding with each multiply-accumulate through the datapath
	typedef struct packed {
		logic       first;   // first term of this output degree
		logic       last;    // last term of this output degree
		logic       fin;     // last term of the whole product
		logic [5:0] degree;
	} tag_t;

	// Controller command to the datapath
	typedef struct packed {
		logic issue;     // a term read is issued this cycle
		logic clr_ops;   // drop both operand stores after this issue
		tag_t tag;
	} ctl_t;

endpackage

>>> rtl/pmul_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmul_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/pmul_ctrl.sv
// Sequencer for the polynomial multiplier: walks output degree k and term i,
// issuing one multiply-accumulate per cycle while adv is high. Depends on pmul_pkg.
module pmul_ctrl #(
	parameter int MAX_TERMS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         adv,
	output logic                         busy,
	output pmul_pkg::ctl_t               ctl,
	output logic [$clog2(MAX_TERMS)-1:0] a_addr,
	output logic [$clog2(MAX_TERMS)-1:0] b_addr
);
	import pmul_pkg::*;

	localparam int AW = $clog2(MAX_TERMS);
	localparam logic [6:0] N_M1   = 7'(MAX_TERMS - 1);
	localparam logic [6:0] LAST_K = 7'(2 * MAX_TERMS - 2);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t        state_q;
	logic [5:0]    k_q;
	logic [AW-1:0] i_q;

	logic [6:0] k_w, i_w, k_nx, lo_cur, lo_nx, hi_cur, j_w;
	logic       first_term, last_term, fin;

	// Term bounds for the current and the next degree
	always_comb begin
		k_w        = {1'b0, k_q};
		i_w        = 7'(i_q);
		k_nx       = k_w + 7'd1;
		hi_cur     = (k_w >= N_M1) ? N_M1 : k_w;
		lo_cur     = (k_w > N_M1) ? (k_w - N_M1) : 7'd0;
		lo_nx      = (k_nx > N_M1) ? (k_nx - N_M1) : 7'd0;
		j_w        = k_w - i_w;
		first_term = (i_w == lo_cur);
		last_term  = (i_w == hi_cur);
		fin        = last_term && (k_w == LAST_K);
	end

	assign a_addr = i_q;
	assign b_addr = j_w[AW-1:0];
	assign busy   = (state_q != ST_IDLE);

	// Command out
	always_comb begin
		ctl.issue      = (state_q == ST_RUN);
		ctl.clr_ops    = (state_q == ST_RUN) && fin;
		ctl.tag.first  = first_term;
		ctl.tag.last   = last_term;
		ctl.tag.fin    = fin;
		ctl.tag.degree = k_q;
	end

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						k_q     <= '0;
						i_q     <= '0;
					end
				end
				ST_RUN: begin
					if (adv) begin
						if (fin) begin
							state_q <= ST_IDLE;
						end else if (last_term) begin
							k_q <= k_nx[5:0];
							i_q <= lo_nx[AW-1:0];
						end else begin
							i_q <= i_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/pmul_dp.sv
// Datapath for the polynomial multiplier: operand RAMs with valid bits, a
// shared multiplier, accumulator and the result register. Uses pmul_pkg, pmul_ram.
module pmul_dp #(
	parameter int MAX_TERMS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load_a,
	input  logic                         load_b,
	input  logic [$clog2(MAX_TERMS)-1:0] load_addr,
	input  logic [31:0]                  load_data,
	input  pmul_pkg::ctl_t               ctl,
	input  logic [$clog2(MAX_TERMS)-1:0] a_addr,
	input  logic [$clog2(MAX_TERMS)-1:0] b_addr,
	output logic                         adv,
	output pmul_pkg::result_t            result,
	output logic                         result_valid,
	input  logic                         result_stall
);
	import pmul_pkg::*;

	logic                 rd_en;
	logic [31:0]          a_rd, b_rd;
	logic [MAX_TERMS-1:0] a_vld_q, b_vld_q;

	logic        v_s1, aok_s1, bok_s1;
	tag_t        tag_s1;
	logic        v_s2;
	tag_t        tag_s2;
	logic [31:0] prod_s2;
	logic [31:0] acc_q, sum;
	logic        rv_q;
	result_t     res_q;

	// Whole pipeline freezes when a finished sum meets a full, stalled result
	assign adv   = !(v_s2 && tag_s2.last && rv_q && result_stall);
	assign rd_en = ctl.issue && adv;

	pmul_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_ram_a (
		.clk   (clk),
		.we    (load_a),
		.waddr (load_addr),
		.wdata (load_data),
		.re    (rd_en),
		.raddr (a_addr),
		.rdata (a_rd)
	);

	pmul_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_ram_b (
		.clk   (clk),
		.we    (load_b),
		.waddr (load_addr),
		.wdata (load_data),
		.re    (rd_en),
		.raddr (b_addr),
		.rdata (b_rd)
	);

	// Operand valid bits: unwritten terms read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_q <= '0;
			b_vld_q <= '0;
		end else if (rd_en && ctl.clr_ops) begin
			a_vld_q <= '0;
			b_vld_q <= '0;
		end else begin
			if (load_a) a_vld_q[load_addr] <= 1'b1;
			if (load_b) b_vld_q[load_addr] <= 1'b1;
		end
	end

	// Stage 1: read data, tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			tag_s1 <= ctl.tag;
			aok_s1 <= a_vld_q[a_addr];
			bok_s1 <= b_vld_q[b_addr];
		end
	end

	// Stage 2: multiply, low 32 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			tag_s2  <= tag_s1;
			prod_s2 <= 32'((aok_s1 ? a_rd : 32'd0) * (bok_s1 ? b_rd : 32'd0));
		end
	end

	// Accumulate
	assign sum = tag_s2.first ? prod_s2 : (acc_q + prod_s2);

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			acc_q <= sum;
		end
		if (adv && v_s2 && tag_s2.last) begin
			res_q.result_degree      <= tag_s2.degree;
			res_q.result_coefficient <= sum;
			res_q.last               <= tag_s2.fin;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (adv && v_s2 && tag_s2.last) begin
			rv_q <= 1'b1;
		end else if (!result_stall) begin
			rv_q <= 1'b0;
		end
	end

	assign result       = res_q;
	assign result_valid = rv_q;

endmodule

>>> rtl/polynomial_multiplier_unit.sv
// Top level of the polynomial multiplier: item decode, sequencer and datapath.
// Depends on pmul_pkg, pmul_ctrl, pmul_dp (and pmul_ram through pmul_dp).
//
// Usage:
//   Item channel (item, item_valid, item_stall): mode 0 and 1 beats load one
//   coefficient of the first or second operand at its degree; a degree of
//   MAX_TERMS or more, and mode 3, are dropped. A mode 2 beat multiplies the
//   operands and sends 2*MAX_TERMS-1 result beats (degree 0 upward, last set
//   on the final one), and clears both operands to zero when its last term
//   is read. Terms never loaded count as zero.
//   Result channel (result, result_valid, result_stall): one output register.
//   Compute runs one multiply-accumulate per cycle, unless the pipeline is
//   frozen, on a single shared multiplier: MAX_TERMS*MAX_TERMS terms issue
//   (1024 at 32 terms). Each degree's result_valid rises once its final term
//   has passed the read stage, the multiply stage and the accumulator into the
//   result register. item_stall is high while the sequencer issues terms; the
//   next item can be taken in the cycle after the last term issues.
//   When result_stall holds a finished coefficient back, the whole multiply
//   pipeline freezes and resumes without loss.
//   Reset (arst_n low) empties the pipeline and the result register and zeroes
//   both operands at once; no clearing pass is needed.
module polynomial_multiplier_unit #(
	parameter int MAX_TERMS = pmul_pkg::MAX_TERMS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pmul_pkg::item_t   item,
	input  logic              item_valid,
	output logic              item_stall,
	output pmul_pkg::result_t result,
	output logic              result_valid,
	input  logic              result_stall
);
	import pmul_pkg::*;

	localparam int AW = $clog2(MAX_TERMS);

	logic          accept, in_range, start, load_a, load_b, adv, busy;
	ctl_t          ctl;
	logic [AW-1:0] a_addr, b_addr;

	// Item decode
	assign item_stall = busy;
	assign accept     = item_valid && !item_stall;
	assign in_range   = ({1'b0, item.degree} < 6'(MAX_TERMS));
	assign load_a     = accept && (item.mode == MODE_LOAD_A) && in_range;
	assign load_b     = accept && (item.mode == MODE_LOAD_B) && in_range;
	assign start      = accept && (item.mode == MODE_COMPUTE);

	pmul_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.adv    (adv),
		.busy   (busy),
		.ctl    (ctl),
		.a_addr (a_addr),
		.b_addr (b_addr)
	);

	pmul_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_a       (load_a),
		.load_b       (load_b),
		.load_addr    (item.degree[AW-1:0]),
		.load_data    (item.coefficient),
		.ctl          (ctl),
		.a_addr       (a_addr),
		.b_addr       (b_addr),
		.adv          (adv),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

>>> verif/polynomial_multiplier_unit_tb.sv
// Testbench for polynomial_multiplier_unit: directed, random and back-pressure tests,
// each result beat checked against an in-bench model of the product coefficients.
// Depends on pmul_pkg and the polynomial_multiplier_unit RTL.
module polynomial_multiplier_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pmul_pkg::*;

	localparam int TERMS        = MAX_TERMS_DEF;
	localparam int PROD_TERMS   = 2 * TERMS - 1;
	localparam int RANDOM_ITEMS = 120;
	localparam int DRAIN_CYCLES = 32;
	localparam int HOLD_CYCLES  = 400;

	// Mode code the block drops
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic    clk;
	logic    arst_n;
	item_t   item;
	logic    item_valid;
	logic    item_stall;
	result_t result;
	logic    result_valid;
	logic    result_stall;

	// Model state: operand stores and the product terms still to arrive
	logic [31:0] opnd_a [TERMS];
	logic [31:0] opnd_b [TERMS];
	result_t     expected_terms [$];

	int error_count;
	int burst_left;
	int gap_max;
	int hold_left;
	int items_sent;

	polynomial_multiplier_unit #(
		.MAX_TERMS(TERMS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Update the operand model for one accepted beat; a compute queues all product terms
	task automatic apply_item(input item_t it);
		logic [31:0] acc [PROD_TERMS];
		result_t     r;
		int          i;
		int          j;
		int          k;
		case (it.mode)
			MODE_LOAD_A: begin
				if (it.degree < TERMS)
					opnd_a[it.degree] = it.coefficient;
			end
			MODE_LOAD_B: begin
				if (it.degree < TERMS)
					opnd_b[it.degree] = it.coefficient;
			end
			MODE_COMPUTE: begin
				for (k = 0; k < PROD_TERMS; k++)
					acc[k] = '0;
				for (i = 0; i < TERMS; i++)
					for (j = 0; j < TERMS; j++)
						acc[i + j] = acc[i + j] + opnd_a[i] * opnd_b[j];
				for (k = 0; k < PROD_TERMS; k++) begin
					r.result_degree      = k[5:0];
					r.result_coefficient = acc[k];
					r.last               = (k == PROD_TERMS - 1);
					expected_terms.push_back(r);
				end
				for (i = 0; i < TERMS; i++) begin
					opnd_a[i] = '0;
					opnd_b[i] = '0;
				end
			end
			default: ;
		endcase
	endtask

	// Offer one beat, with a random gap between bursts, and hold it until taken
	task automatic send_item(input logic [1:0] mode, input logic [4:0] degree,
			input logic [31:0] coefficient);
		item_t it;
		int    gap;
		it.mode        = mode;
		it.degree      = degree;
		it.coefficient = coefficient;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		apply_item(it);
		burst_left--;
		if (mode != MODE_UNUSED)
			items_sent++;
	endtask

	// Mostly random values, with the extremes mixed in
	function automatic logic [31:0] pick_coef();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h7FFF_FFFF;
			4: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	// Receiver: stall density changes per segment; a long hold-off when asked
	initial begin
		int seg_left;
		int stall_pct;
		seg_left  = 0;
		stall_pct = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				if (seg_left == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 25;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
					seg_left = $urandom_range(10, 120);
				end
				seg_left--;
				result_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Result checker: each accepted beat against the oldest expected term
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_terms.size() == 0) begin
				$error("unexpected result beat: degree %0d coefficient %h",
					result.result_degree, result.result_coefficient);
				error_count++;
			end else begin
				exp_r = expected_terms.pop_front();
				if (result.result_degree !== exp_r.result_degree) begin
					$error("result_degree: expected %0d, actual %0d",
						exp_r.result_degree, result.result_degree);
					error_count++;
				end
				if (result.result_coefficient !== exp_r.result_coefficient) begin
					$error("result_coefficient (degree %0d): expected %h, actual %h",
						exp_r.result_degree, exp_r.result_coefficient,
						result.result_coefficient);
					error_count++;
				end
				if (result.last !== exp_r.last) begin
					$error("last (degree %0d): expected %b, actual %b",
						exp_r.result_degree, exp_r.last, result.last);
					error_count++;
				end
			end
		end
	end

	// Extremes, overwrite, dropped mode, ignored compute fields, clearing after compute
	task automatic test_directed();
		gap_max = 2;
		// empty stores give an all-zero product; degree and coefficient are don't-care
		send_item(MODE_COMPUTE, 5'd31, 32'hFFFF_FFFF);
		send_item(MODE_LOAD_A, 5'd0, 32'h7FFF_FFFF);
		send_item(MODE_LOAD_A, 5'd31, 32'h8000_0000);
		send_item(MODE_LOAD_B, 5'd0, 32'hFFFF_FFFF);
		send_item(MODE_LOAD_B, 5'd31, 32'h7FFF_FFFF);
		send_item(MODE_LOAD_A, 5'd5, 32'h0000_0001);
		send_item(MODE_LOAD_A, 5'd5, 32'h0000_0003);
		send_item(MODE_LOAD_B, 5'd2, 32'h0001_0000);
		// dropped mode must not touch either store
		send_item(MODE_UNUSED, 5'd5, 32'h1234_5678);
		send_item(MODE_UNUSED, 5'd31, 32'hFFFF_FFFF);
		send_item(MODE_COMPUTE, 5'd0, 32'h0000_0000);
		send_item(MODE_LOAD_A, 5'd31, 32'hFFFF_FFFF);
		send_item(MODE_LOAD_B, 5'd31, 32'hFFFF_FFFF);
		send_item(MODE_LOAD_A, 5'd16, 32'h8000_0000);
		send_item(MODE_LOAD_B, 5'd15, 32'h8000_0000);
		send_item(MODE_COMPUTE, 5'd17, 32'hA5A5_A5A5);
		// operands were cleared by the compute above
		send_item(MODE_COMPUTE, 5'd0, 32'h0000_0000);
		// only one operand loaded
		send_item(MODE_LOAD_A, 5'd10, 32'h0BAD_F00D);
		send_item(MODE_COMPUTE, 5'd31, 32'h5A5A_5A5A);
	endtask

	// Random polynomials: mostly load-then-compute, some noise and skipped computes
	task automatic test_random();
		int n_a;
		int n_b;
		int done_a;
		int done_b;
		bit full_a;
		bit full_b;
		while (items_sent < RANDOM_ITEMS) begin
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			full_a  = ($urandom_range(0, 9) == 0);
			full_b  = ($urandom_range(0, 9) == 0);
			n_a     = full_a ? TERMS : $urandom_range(0, 6);
			n_b     = full_b ? TERMS : $urandom_range(0, 6);
			done_a  = 0;
			done_b  = 0;
			while (done_a < n_a || done_b < n_b) begin
				if ($urandom_range(0, 9) == 0)
					send_item(MODE_UNUSED, 5'($urandom()), $urandom());
				if (done_b >= n_b || (done_a < n_a && $urandom_range(0, 1) == 0)) begin
					send_item(MODE_LOAD_A,
						5'(full_a ? done_a : $urandom_range(0, TERMS - 1)),
						pick_coef());
					done_a++;
				end else begin
					send_item(MODE_LOAD_B,
						5'(full_b ? done_b : $urandom_range(0, TERMS - 1)),
						pick_coef());
					done_b++;
				end
			end
			// now and then the compute is left out and loads pile onto the same stores
			if ($urandom_range(0, 7) != 0)
				send_item(MODE_COMPUTE, 5'($urandom()), $urandom());
		end
	endtask

	// Receiver holds off while the sender keeps offering, so input stalls build up
	task automatic test_backpressure();
		int i;
		gap_max   = 0;
		hold_left = HOLD_CYCLES;
		for (i = 0; i < 4; i++) begin
			send_item(MODE_LOAD_A, 5'($urandom_range(0, TERMS - 1)), pick_coef());
			send_item(MODE_LOAD_B, 5'($urandom_range(0, TERMS - 1)), pick_coef());
		end
		send_item(MODE_COMPUTE, 5'($urandom()), $urandom());
		for (i = 0; i < 10; i++)
			send_item(2'($urandom_range(0, 1)), 5'($urandom_range(0, TERMS - 1)),
				pick_coef());
		send_item(MODE_COMPUTE, 5'($urandom()), $urandom());
	endtask

	initial begin
		int i;
		error_count = 0;
		burst_left  = 0;
		gap_max     = 0;
		hold_left   = 0;
		items_sent  = 0;
		for (i = 0; i < TERMS; i++) begin
			opnd_a[i] = '0;
			opnd_b[i] = '0;
		end
		arst_n     = 1'b0;
		item       = '0;
		item_valid = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random();
		test_backpressure();

		item_valid <= 1'b0;
		while (expected_terms.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Run limit
	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

endmodule
